/* rtl/gap_pkg.sv */
`default_nettype none
package gap_pkg;

  localparam int SAMPLE_WIDTH = 16;
  localparam int COUNT_WIDTH = 21;
  localparam int SUM_WIDTH = SAMPLE_WIDTH + COUNT_WIDTH;
  localparam int STEP_WIDTH = $clog2(SAMPLE_WIDTH);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_WIDTH = $clog2(QUEUE_DEPTH);

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic signed [SUM_WIDTH-1:0] sum_t;
  typedef logic [SUM_WIDTH-1:0] mag_t;
  typedef logic [SAMPLE_WIDTH-1:0] quot_t;
  typedef logic [STEP_WIDTH-1:0] step_t;

  typedef struct packed {
    sum_t   sum;
    count_t count;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_DONE
  } back_state_t;

endpackage
`default_nettype wire

/* rtl/gap_if.sv */
`default_nettype none
interface gap_sample_if import gap_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface gap_average_if import gap_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t average;

  modport source (output valid, output average, input ready);
  modport sink (input valid, input average, output ready);
endinterface
`default_nettype wire

/* rtl/global_average_pool_core.sv */
`default_nettype none
// Global average pooling over a stream of signed Q8.8 samples sent channel by channel.
// The front accumulates one sample per cycle while the queue is not full and, on the last
// sample of a channel, hands the channel sum and count to a two-entry queue. A serial
// divider takes each queued channel in turn: it loads the channel, forms one quotient bit
// per cycle for 16 bits, then fills the output register once that register is free. The
// front keeps accepting samples while the divider works, as long as the queue has room.
// A spatial_count of zero acts as one.
module global_average_pool_core import gap_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     cfg_wr_en,
  input  wire count_t   cfg_wr_data,
  gap_sample_if.sink    samples,
  gap_average_if.source averages
);

  count_t        spatial_count;
  logic          push;
  job_t          push_job;
  logic          pop;
  job_t          head;
  queue_status_t status;

  always_ff @(posedge clk) begin
    if (rst) begin
      spatial_count <= count_t'(1);
    end else if (cfg_wr_en) begin
      spatial_count <= cfg_wr_data;
    end
  end

  gap_front u_front (
    .clk           (clk),
    .rst           (rst),
    .spatial_count (spatial_count),
    .samples       (samples),
    .queue_full    (status.full),
    .push          (push),
    .push_job      (push_job)
  );

  gap_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .status   (status)
  );

  gap_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .queue_empty (status.empty),
    .pop         (pop),
    .averages    (averages)
  );

endmodule
`default_nettype wire

/* rtl/gap_front.sv */
`default_nettype none
module gap_front import gap_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire count_t spatial_count,
  gap_sample_if.sink  samples,
  input  wire logic   queue_full,
  output logic        push,
  output job_t        push_job
);

  sum_t   running_sum;
  count_t seen_count;
  sum_t   sum_next;
  count_t count_next;
  count_t limit;
  logic   close;
  logic   take;

  assign samples.ready = !queue_full;
  assign take = samples.valid && samples.ready;

  always_comb begin
    limit = (spatial_count == '0) ? count_t'(1) : spatial_count;
    sum_next = running_sum + sum_t'(samples.sample);
    count_next = seen_count + count_t'(1);
    close = (count_next >= limit);
  end

  assign push = take && close;
  assign push_job = '{sum: sum_next, count: count_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= '0;
      seen_count <= '0;
    end else if (take) begin
      if (close) begin
        running_sum <= '0;
        seen_count <= '0;
      end else begin
        running_sum <= sum_next;
        seen_count <= count_next;
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/gap_queue.sv */
`default_nettype none
module gap_queue import gap_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire job_t  push_job,
  input  wire logic  pop,
  output job_t       head,
  output queue_status_t status
);

  job_t                 entries [QUEUE_DEPTH];
  logic [QPTR_WIDTH-1:0] wr_ptr;
  logic [QPTR_WIDTH-1:0] rd_ptr;
  logic [QPTR_WIDTH:0]   fill;

  assign status.full = (fill == (QPTR_WIDTH+1)'(QUEUE_DEPTH));
  assign status.empty = (fill == '0);
  assign head = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule
`default_nettype wire

/* rtl/gap_back.sv */
`default_nettype none
module gap_back import gap_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire job_t  head,
  input  wire logic  queue_empty,
  output logic       pop,
  gap_average_if.source averages
);

  back_state_t state;
  back_state_t state_next;
  mag_t        rem;
  mag_t        divisor;
  quot_t       quot;
  step_t       step;
  logic        neg;
  logic        out_valid;
  sample_t     out_data;
  logic        load_out;
  logic        fits;
  mag_t        head_mag;

  always_comb begin
    case (state)
      S_IDLE:  state_next = queue_empty ? S_IDLE : S_DIV;
      S_DIV:   state_next = (step == '0) ? S_DONE : S_DIV;
      S_DONE:  state_next = (!out_valid || averages.ready) ? S_IDLE : S_DONE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    pop = 1'b0;
    load_out = 1'b0;
    case (state)
      S_IDLE:  pop = !queue_empty;
      S_DONE:  load_out = !out_valid || averages.ready;
      default: ;
    endcase
  end

  assign head_mag = head.sum[SUM_WIDTH-1] ? mag_t'(-head.sum) : mag_t'(head.sum);
  assign fits = (rem >= divisor);

  always_ff @(posedge clk) begin
    if (pop) begin
      neg <= head.sum[SUM_WIDTH-1];
      rem <= head_mag;
      divisor <= mag_t'(head.count) << (SAMPLE_WIDTH - 1);
      quot <= '0;
      step <= step_t'(SAMPLE_WIDTH - 1);
    end else if (state == S_DIV) begin
      if (fits) begin
        rem <= rem - divisor;
      end
      divisor <= divisor >> 1;
      quot <= {quot[SAMPLE_WIDTH-2:0], fits};
      step <= step - 1'b1;
    end
    if (load_out) begin
      out_data <= neg ? sample_t'(-quot) : sample_t'(quot);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (averages.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign averages.valid = out_valid;
  assign averages.average = out_data;

endmodule
`default_nettype wire
